// File: hw/rtl/dtc_pkg.sv
`default_nettype none

package dtc_pkg;

    // table size and derived widths
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int CODE_W = 24;
    localparam int STAT_W = 8;
    localparam int SEV_W  = 8;

    // UDS status bits
    localparam logic [STAT_W-1:0] STS_FAILED        = 8'h01;
    localparam logic [STAT_W-1:0] STS_FAILED_CYCLE  = 8'h02;
    localparam logic [STAT_W-1:0] STS_PENDING       = 8'h04;
    localparam logic [STAT_W-1:0] STS_CONFIRMED     = 8'h08;
    localparam logic [STAT_W-1:0] STS_FAILED_CLEAR  = 8'h20;
    localparam logic [STAT_W-1:0] STS_NOTDONE_CYCLE = 8'h40;
    localparam logic [STAT_W-1:0] STS_FRESH         = 8'h50;

    localparam logic [CODE_W-1:0] CODE_ALL   = 24'hFFFFFF;
    localparam logic [STAT_W-1:0] STATUS_ALL = 8'hFF;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_TEST     = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_COUNT    = 3'd3,
        OP_CYCLE    = 3'd4,
        OP_LOOKUP   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_FULL      = 2'd1,
        RC_DUP       = 2'd2,
        RC_NOT_FOUND = 2'd3
    } rc_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [STAT_W-1:0] status;
        logic [SEV_W-1:0]  severity;
    } entry_t;

    // write request into the entry store
    typedef struct packed {
        logic   en_all;     // write code, status and severity
        logic   en_status;  // write status only
        idx_t   addr;
        entry_t data;
    } wr_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/dtc_store.sv
`default_nettype none

// Entry store: one write port, one read port with registered read data.
module dtc_store
    import dtc_pkg::*;
(
    input  wire logic    aclk,
    input  wire idx_t    rd_addr,
    output entry_t       rd_data,
    input  wire wr_req_t wr
);

    logic [CODE_W-1:0] code_mem [MAX_ENTRIES];
    logic [STAT_W-1:0] stat_mem [MAX_ENTRIES];
    logic [SEV_W-1:0]  sev_mem  [MAX_ENTRIES];

    // writes
    always_ff @(posedge aclk) begin
        if (wr.en_all) begin
            code_mem[wr.addr] <= wr.data.code;
            sev_mem[wr.addr]  <= wr.data.severity;
        end
        if (wr.en_all || wr.en_status) begin
            stat_mem[wr.addr] <= wr.data.status;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_data.code     <= code_mem[rd_addr];
        rd_data.status   <= stat_mem[rd_addr];
        rd_data.severity <= sev_mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/diagnostic_code_status_table_unit.sv
`default_nettype none

// Channel   Dir  Word                                              Bits
// s_        in   tuser: opcode                                     3
//                tdata: code, severity, failed, clear_mask,
//                       count_mask                                 72
// m_        out  tdata: result_code, entry_index, match_count,
//                       entry_status, entry_severity               32
//
// The sequencer walks the used slots one per cycle through the store's single read
// port, and a search stops at its first hit. Full table and unused opcodes skip
// the walk and go straight to the finishing state.
// s_tready is high only while idle; the result sits in an output register
// and a stalled m_ side holds the next result in the finishing state.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module diagnostic_code_status_table_unit
    import dtc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // code, severity, failed, clear_mask, count_mask
    input  wire logic [2:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // result_code, entry_index, match_count,
                                        // entry_status, entry_severity
);

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [SEV_W-1:0]  sev_reg, sev_next;
    logic              failed_reg, failed_next;
    logic [CODE_W-1:0] gmask_reg, gmask_next;
    logic [STAT_W-1:0] smask_reg, smask_next;
    cnt_t              cnt_reg, cnt_next;
    cnt_t              ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    idx_t              pidx_reg, pidx_next;
    cnt_t              tally_reg, tally_next;
    rc_t               res_rc_reg, res_rc_next;
    idx_t              res_idx_reg, res_idx_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic [SEV_W-1:0]  res_sev_reg, res_sev_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    idx_t              rd_addr;
    entry_t            rd_data;
    wr_req_t           wr;
    logic              more;
    logic              done;
    logic [STAT_W-1:0] test_st;

    dtc_store u_store (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // slots still to be read
    assign more = (ptr_reg < cnt_reg);

    // status after a test report on the entry being examined
    always_comb begin
        test_st = rd_data.status & ~STS_FRESH;
        if (failed_reg) begin
            test_st = test_st | STS_FAILED | STS_FAILED_CYCLE | STS_PENDING
                    | STS_CONFIRMED | STS_FAILED_CLEAR;
        end else begin
            test_st = test_st & ~(STS_FAILED | STS_FAILED_CYCLE | STS_PENDING);
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        code_next     = code_reg;
        sev_next      = sev_reg;
        failed_next   = failed_reg;
        gmask_next    = gmask_reg;
        smask_next    = smask_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        tally_next    = tally_reg;
        res_rc_next   = res_rc_reg;
        res_idx_next  = res_idx_reg;
        res_st_next   = res_st_reg;
        res_sev_next  = res_sev_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = ptr_reg[IDX_W-1:0];
        wr            = '0;
        done          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    code_next    = s_tdata[23:0];
                    sev_next     = s_tdata[31:24];
                    failed_next  = s_tdata[32];
                    gmask_next   = s_tdata[56:33];
                    smask_next   = s_tdata[64:57];
                    ptr_next     = '0;
                    tally_next   = '0;
                    res_rc_next  = RC_OK;
                    res_idx_next = '0;
                    res_st_next  = '0;
                    res_sev_next = '0;
                    state_next   = S_SCAN;
                    unique case (opcode_t'(s_tuser))
                        OP_REGISTER: begin
                            if (cnt_reg == CNT_W'(MAX_ENTRIES)) begin
                                res_rc_next = RC_FULL;
                                state_next  = S_DONE;
                            end
                        end
                        OP_TEST, OP_CLEAR, OP_COUNT, OP_CYCLE, OP_LOOKUP: begin
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN: begin
                // issue next read
                if (more) begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end
                // examine the word read last cycle
                if (pend_reg) begin
                    unique case (opcode_t'(op_reg))
                        OP_REGISTER: begin
                            if (rd_data.code == code_reg) begin
                                res_rc_next  = RC_DUP;
                                res_idx_next = pidx_reg;
                                res_st_next  = rd_data.status;
                                res_sev_next = rd_data.severity;
                                done         = 1'b1;
                            end
                        end
                        OP_TEST: begin
                            if (rd_data.code == code_reg) begin
                                wr.en_status   = 1'b1;
                                wr.addr        = pidx_reg;
                                wr.data.status = test_st;
                                res_rc_next    = RC_OK;
                                res_idx_next   = pidx_reg;
                                res_st_next    = test_st;
                                res_sev_next   = rd_data.severity;
                                done           = 1'b1;
                            end
                        end
                        OP_LOOKUP: begin
                            if (rd_data.code == code_reg) begin
                                res_rc_next  = RC_OK;
                                res_idx_next = pidx_reg;
                                res_st_next  = rd_data.status;
                                res_sev_next = rd_data.severity;
                                done         = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            if (gmask_reg == CODE_ALL
                                || (rd_data.code & gmask_reg) == gmask_reg) begin
                                wr.en_status   = 1'b1;
                                wr.addr        = pidx_reg;
                                wr.data.status = STS_FRESH;
                            end
                        end
                        OP_COUNT: begin
                            if (smask_reg == STATUS_ALL
                                || (rd_data.status & smask_reg) != '0) begin
                                tally_next = tally_reg + 1'b1;
                            end
                        end
                        OP_CYCLE: begin
                            wr.en_status   = 1'b1;
                            wr.addr        = pidx_reg;
                            wr.data.status = (rd_data.status & ~STS_FAILED_CYCLE)
                                           | STS_NOTDONE_CYCLE;
                        end
                        default: begin
                        end
                    endcase
                end
                // walk finished without a hit
                if (!done && !pend_reg && !more) begin
                    done = 1'b1;
                    unique case (opcode_t'(op_reg))
                        OP_REGISTER: begin
                            wr.en_all        = 1'b1;
                            wr.addr          = cnt_reg[IDX_W-1:0];
                            wr.data.code     = code_reg;
                            wr.data.status   = STS_FRESH;
                            wr.data.severity = sev_reg;
                            cnt_next         = cnt_reg + 1'b1;
                            res_rc_next      = RC_OK;
                            res_idx_next     = cnt_reg[IDX_W-1:0];
                            res_st_next      = STS_FRESH;
                            res_sev_next     = sev_reg;
                        end
                        OP_TEST, OP_LOOKUP: res_rc_next = RC_NOT_FOUND;
                        default:            res_rc_next = RC_OK;
                    endcase
                end
                if (done) begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {3'b000, res_sev_reg, res_st_reg, 6'(tally_reg),
                                     5'(res_idx_reg), res_rc_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        code_reg    <= code_next;
        sev_reg     <= sev_next;
        failed_reg  <= failed_next;
        gmask_reg   <= gmask_next;
        smask_reg   <= smask_next;
        ptr_reg     <= ptr_next;
        pidx_reg    <= pidx_next;
        tally_reg   <= tally_next;
        res_rc_reg  <= res_rc_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        res_sev_reg <= res_sev_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
